// ===== rtl/dnsae_pkg.sv =====
// shared types and constants for the dns answer address extractor
package dnsae_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CntW    = 4;
  localparam int unsigned CodeW   = 4;
  localparam int unsigned AddrW   = 32;
  localparam int unsigned StatusW = 2;

  localparam logic [ByteW-1:0] CodeMask = 8'h0F;
  localparam logic [ByteW-1:0] PtrMask  = 8'hC0;

  // header byte holding the response code, last byte of each fixed field
  localparam logic [CntW-1:0] HdrCodeIdx = 4'd3;
  localparam logic [CntW-1:0] HdrLastIdx = 4'd11;
  localparam logic [CntW-1:0] QTailLast  = 4'd3;
  localparam logic [CntW-1:0] Skip10Last = 4'd9;
  localparam logic [CntW-1:0] AddrLast   = 4'd3;

  typedef enum logic [StatusW-1:0] {
    StFound     = 2'd0,
    StCodeError = 2'd1,
    StTruncated = 2'd2
  } status_e;

  typedef enum logic [7:0] {
    PhHeader = 8'b0000_0001,
    PhQName  = 8'b0000_0010,
    PhQTail  = 8'b0000_0100,
    PhAFirst = 8'b0000_1000,
    PhAPtr   = 8'b0001_0000,
    PhALabel = 8'b0010_0000,
    PhSkip10 = 8'b0100_0000,
    PhAddr   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             last_byte;
  } req_t;

  typedef struct packed {
    status_e          status;
    logic [CodeW-1:0] rcode;
    logic [AddrW-1:0] address;
  } res_t;

endpackage

// ===== rtl/dnsae_if.sv =====
// request and result channel interfaces
interface dnsae_req_if;
  logic                          valid;
  logic                          ready;
  logic [dnsae_pkg::ByteW-1:0]   data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dnsae_res_if;
  logic                          valid;
  logic                          ready;
  dnsae_pkg::status_e            status;
  logic [dnsae_pkg::CodeW-1:0]   rcode;
  logic [dnsae_pkg::AddrW-1:0]   address;

  modport source (output valid, output status, output rcode, output address,
                  input ready);
  modport sink   (input valid, input status, input rcode, input address,
                  output ready);
endinterface

// ===== rtl/dnsae_parse.sv =====
// packet walk state and the per-byte state update
module dnsae_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  dnsae_pkg::req_t  req_i,
  output logic             res_valid_o,
  output dnsae_pkg::res_t  res_o
);

  dnsae_pkg::phase_e                 phase_q, phase_d;
  logic [dnsae_pkg::CntW-1:0]        cnt_q, cnt_d;
  logic [dnsae_pkg::CodeW-1:0]       code_q, code_d;
  logic [dnsae_pkg::AddrW-1:0]       addr_q, addr_d;
  logic                              given_q, given_d;
  logic [dnsae_pkg::ByteW-1:0]       b;
  logic [dnsae_pkg::CntW-1:0]        cnt_inc;

  assign b       = req_i.data_byte;
  assign cnt_inc = cnt_q + 4'd1;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    code_d      = code_q;
    addr_d      = addr_q;
    given_d     = given_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (!given_q) begin
      unique case (phase_q)
        dnsae_pkg::PhHeader: begin
          if (cnt_q == dnsae_pkg::HdrCodeIdx) begin
            code_d = dnsae_pkg::CodeW'(b & dnsae_pkg::CodeMask);
            if (code_d != '0) begin
              res_valid_o   = 1'b1;
              res_o.status  = dnsae_pkg::StCodeError;
              res_o.rcode   = code_d;
              given_d       = 1'b1;
            end
          end
          if (cnt_q >= dnsae_pkg::HdrLastIdx) begin
            phase_d = dnsae_pkg::PhQName;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        dnsae_pkg::PhQName: begin
          if (b == '0) begin
            phase_d = dnsae_pkg::PhQTail;
            cnt_d   = '0;
          end
        end
        dnsae_pkg::PhQTail: begin
          if (cnt_q >= dnsae_pkg::QTailLast) begin
            phase_d = dnsae_pkg::PhAFirst;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        dnsae_pkg::PhAFirst: begin
          // either top bit set marks a compressed pointer
          if ((b & dnsae_pkg::PtrMask) != '0) begin
            phase_d = dnsae_pkg::PhAPtr;
          end else if (b == '0) begin
            phase_d = dnsae_pkg::PhSkip10;
          end else begin
            phase_d = dnsae_pkg::PhALabel;
          end
          cnt_d = '0;
        end
        dnsae_pkg::PhAPtr: begin
          phase_d = dnsae_pkg::PhSkip10;
          cnt_d   = '0;
        end
        dnsae_pkg::PhALabel: begin
          if (b == '0) begin
            phase_d = dnsae_pkg::PhSkip10;
            cnt_d   = '0;
          end
        end
        dnsae_pkg::PhSkip10: begin
          if (cnt_q >= dnsae_pkg::Skip10Last) begin
            phase_d = dnsae_pkg::PhAddr;
            cnt_d   = '0;
            addr_d  = '0;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        dnsae_pkg::PhAddr: begin
          addr_d = {addr_q[dnsae_pkg::AddrW-dnsae_pkg::ByteW-1:0], b};
          if (cnt_q >= dnsae_pkg::AddrLast) begin
            res_valid_o   = 1'b1;
            res_o.status  = dnsae_pkg::StFound;
            res_o.rcode   = code_q;
            res_o.address = addr_d;
            given_d       = 1'b1;
          end else begin
            cnt_d = cnt_inc;
          end
        end
        default: begin
          phase_d = dnsae_pkg::PhHeader;
        end
      endcase
    end

    if (req_i.last_byte) begin
      if (!given_d) begin
        res_valid_o   = 1'b1;
        res_o.status  = dnsae_pkg::StTruncated;
        res_o.rcode   = code_d;
        res_o.address = '0;
      end
      phase_d = dnsae_pkg::PhHeader;
      cnt_d   = '0;
      code_d  = '0;
      addr_d  = '0;
      given_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dnsae_pkg::PhHeader;
      cnt_q   <= '0;
      code_q  <= '0;
      addr_q  <= '0;
      given_q <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      code_q  <= code_d;
      addr_q  <= addr_d;
      given_q <= given_d;
    end
  end

endmodule

// ===== rtl/dns_answer_address_extractor_core.sv =====
// top level: dns reply byte parser giving the first answer's ipv4 address
//
//   channel  dir  payload                              handshake
//   req_i    in   data_byte[7:0], last_byte            valid / ready
//   res_o    out  status[1:0], rcode[3:0],             valid / ready
//                 address[31:0]
//
// one request per cycle sustained unless a result waits on res_o.ready; a request passes
// through the request register, then the parse step into the result register
// the parse state holds one small update per byte, set by the walk state machine
// reset clears the walk state and both valid flags; the parser starts in the header
// while a result waits, the request register holds and ready drops once it is full
module dns_answer_address_extractor_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  dnsae_req_if.sink         req_i,
  dnsae_res_if.source       res_o
);

  logic              in_valid_q;
  dnsae_pkg::req_t   in_q;
  logic              out_valid_q;
  dnsae_pkg::res_t   out_q;
  logic              advance;
  logic              step;
  logic              step_res_valid;
  dnsae_pkg::res_t   step_res;

  // the held request moves on whenever the result register can take a new one
  assign advance     = !out_valid_q || res_o.ready;
  assign step        = in_valid_q && advance;
  assign req_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_q.data_byte <= req_i.data_byte;
      in_q.last_byte <= req_i.last_byte;
    end
  end

  dnsae_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .req_i       (in_q),
    .res_valid_o (step_res_valid),
    .res_o       (step_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= step && step_res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && step_res_valid) begin
      out_q <= step_res;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.status  = out_q.status;
  assign res_o.rcode   = out_q.rcode;
  assign res_o.address = out_q.address;

  a_addr_zero_unless_found : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status != dnsae_pkg::StFound) |-> out_q.address == '0)
    else $error("address nonzero on an error result");

  a_result_loaded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && step_res_valid |=> out_valid_q)
    else $error("parse result not captured");

  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> req_i.ready)
    else $error("request stalled with empty result register");

  a_code_error_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == dnsae_pkg::StCodeError) |-> out_q.rcode != '0)
    else $error("code error result with zero response code");

endmodule
